// ----- src/rotate_then_translate_waypoint_sequencer_macros.svh -----
// assertion macros for the waypoint sequencer
// uses clk and arst_n of the including module
`ifndef ROTATE_THEN_TRANSLATE_WAYPOINT_SEQUENCER_MACROS_SVH
`define ROTATE_THEN_TRANSLATE_WAYPOINT_SEQUENCER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RTTW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RTTW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RTTW_ASSERT_IMP(lbl, ante, cons, msg)
`define RTTW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/rttw_pkg.sv -----
// shared types and constants of the waypoint sequencer
// no dependencies
`default_nettype none
package rttw_pkg;
	localparam int MAX_WAYPOINTS_DEF = 256;
	localparam int POS_WIDTH_DEF = 24;
	localparam int ANGLE_WIDTH_DEF = 16;

	localparam int CFG_W = 40;
	localparam int CFG_IDX_W = 3;
	localparam int CLAMP_W = 22;
	localparam int SQ_W = 44;
	localparam logic [CLAMP_W-1:0] DIST_CLAMP = 22'h200000;

	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_RAD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FINAL_RAD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEVIATION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_THR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REPLAN_EN = 3'd5;

	localparam logic [CFG_W-1:0] ACCEPT_RAD_RST = 40'd10486;
	localparam logic [CFG_W-1:0] FINAL_RAD_RST = 40'd4096;
	localparam logic [CFG_W-1:0] DEVIATION_RST = 40'd262144;
	localparam logic [15:0] YAW_THR_RST = 16'd2731;
	localparam logic [15:0] HOLD_RST = 16'd10;

	typedef enum logic [1:0] {PH_IDLE, PH_ROT, PH_TRANS, PH_DONE} phase_t;
	typedef enum logic [1:0] {FN_LOAD, FN_ODOM, FN_TICK, FN_NONE} func_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic odom;
		logic res_plain;
		logic rot;
		logic trans_start;
		logic rd_idx;
		logic rd_dist;
		logic rd_scan;
		logic eval;
		logic enter;
		logic emit;
	} cmd_t;

	typedef struct packed {
		func_t  func;
		logic   last;
		logic   active;
		phase_t phase;
		logic   replan_en;
		logic   pipe_busy;
		logic   scan_last;
		logic   advance;
		logic   out_blocked;
	} status_t;
endpackage
`default_nettype wire

// ----- src/rotate_then_translate_waypoint_sequencer.sv -----
// Waypoint sequencer: rotate to the waypoint heading, then translate to it.
// Input stream: tuser carries the item kind (load, odometry, tick), tdata the
// position and heading, tlast marks the final waypoint of a path on loads.
// Output stream: one beat per tick and one per closed path; tuser is the cause.
// Config channel: cfg_index selects a register, cfg_data holds the value; it is
// always ready and must only be written while the block is idle.
// One item at a time: load and odometry items end at decode, an idle or
// rotating tick goes on to its result, and a closing load first reads the
// first waypoint's heading. A translating tick runs the waypoint through a
// 4-stage distance pipeline off the single memory read port; with replan on,
// a minimum scan reads one stored waypoint per cycle; an advance reads a heading.
// A finished result sits in an output register; the block takes the next item
// while it waits, and stalls before its own next result until it is taken.
// Reset clears all control state and config to defaults; no clearing pass runs,
// the waypoint memory is only read within a loaded path.
// depends on rttw_pkg, rttw_ctrl, rttw_datapath
`default_nettype none
module rotate_then_translate_waypoint_sequencer #(
	parameter int MAX_WAYPOINTS = rttw_pkg::MAX_WAYPOINTS_DEF,
	parameter int POS_WIDTH = rttw_pkg::POS_WIDTH_DEF,
	parameter int ANGLE_WIDTH = rttw_pkg::ANGLE_WIDTH_DEF,
	localparam int IN_W = ((3 * POS_WIDTH + ANGLE_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((3 * POS_WIDTH + 13 + 7) / 8) * 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// pos_x, pos_y, pos_z, heading
	input  wire logic [IN_W-1:0]                s_axis_tdata,
	// func
	input  wire logic [1:0]                     s_axis_tuser,
	// last_entry
	input  wire logic                           s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// phase, set_x, set_y, set_z, set_valid, wp_number, mission_done, replan_request
	output logic [OUT_W-1:0]                    m_axis_tdata,
	// cause
	output logic                                m_axis_tuser,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rttw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rttw_pkg::CFG_W-1:0]     cfg_data
);
	rttw_pkg::cmd_t cmd;
	rttw_pkg::status_t st;

	rttw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	rttw_datapath #(
		.MAX_WAYPOINTS (MAX_WAYPOINTS),
		.POS_WIDTH     (POS_WIDTH),
		.ANGLE_WIDTH   (ANGLE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_user   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_user  (m_axis_tuser),
		.out_data  (m_axis_tdata),
		.cmd       (cmd),
		.st        (st)
	);
endmodule
`default_nettype wire

// ----- src/rttw_datapath.sv -----
// datapath: config registers, waypoint memory, distance pipeline, state and result registers
// depends on rttw_pkg
`default_nettype none
module rttw_datapath #(
	parameter int MAX_WAYPOINTS = rttw_pkg::MAX_WAYPOINTS_DEF,
	parameter int POS_WIDTH = rttw_pkg::POS_WIDTH_DEF,
	parameter int ANGLE_WIDTH = rttw_pkg::ANGLE_WIDTH_DEF,
	localparam int ENT_W = 3 * POS_WIDTH + ANGLE_WIDTH,
	localparam int IN_W = ((ENT_W + 7) / 8) * 8,
	localparam int OUT_W = ((3 * POS_WIDTH + 13 + 7) / 8) * 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [1:0]                      in_user,
	input  wire logic [IN_W-1:0]                 in_data,
	input  wire logic                            in_last,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [rttw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rttw_pkg::CFG_W-1:0]      cfg_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 out_user,
	output logic [OUT_W-1:0]                     out_data,
	input  wire rttw_pkg::cmd_t                  cmd,
	output rttw_pkg::status_t                    st
);
	localparam int P = POS_WIDTH;
	localparam int A = ANGLE_WIDTH;
	localparam int IDX_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
	localparam int CNT_W = IDX_W + 1;
	localparam int MAG_W = (P + 1 > rttw_pkg::CLAMP_W) ? P + 1 : rttw_pkg::CLAMP_W;
	localparam int ERR_W = (A > 16) ? A : 16;
	localparam int SQ_W = rttw_pkg::SQ_W;
	localparam logic [A-1:0] HALF = {1'b1, {(A-1){1'b0}}};

	function automatic logic [A-1:0] herr(input logic [A-1:0] t, input logic [A-1:0] h);
		logic [A-1:0] d;
		d = t - h;
		herr = (d > HALF) ? (~d + 1'b1) : d;
	endfunction

	function automatic logic [rttw_pkg::CLAMP_W-1:0] mag(input logic [P-1:0] a,
		input logic [P-1:0] b);
		logic [P:0] d;
		logic [P:0] m;
		logic [MAG_W-1:0] w;
		d = {a[P-1], a} - {b[P-1], b};
		m = d[P] ? (~d + 1'b1) : d;
		w = MAG_W'(m);
		mag = (w > MAG_W'(rttw_pkg::DIST_CLAMP)) ? rttw_pkg::DIST_CLAMP
			: w[rttw_pkg::CLAMP_W-1:0];
	endfunction

	// config
	logic [rttw_pkg::CFG_W-1:0] acc_rad_q, fin_rad_q, dev_q;
	logic [15:0] thr_q, hold_q;
	logic ren_q;

	// latched item
	rttw_pkg::func_t func_q;
	logic [ENT_W-1:0] ent_q;
	logic last_q;

	// sequencer state
	logic [CNT_W-1:0] pl_q, lp_q;
	logic loading_q;
	logic [IDX_W-1:0] idx_q, scan_q;
	rttw_pkg::phase_t ph_q;
	logic [A-1:0] tgt_hd_q, dhd_q;
	logic [15:0] align_q;
	logic [P-1:0] pose_x_q, pose_y_q, pose_z_q;
	logic odom_q, fin_q;

	// memory and distance pipeline
	logic [ENT_W-1:0] mem_q [MAX_WAYPOINTS];
	logic [ENT_W-1:0] rd_s1;
	logic v_s1, v_s2, v_s3, v_s4, t_s1, t_s2, t_s3, t_s4;
	logic [rttw_pkg::CLAMP_W-1:0] mx_s2, my_s2, mz_s2;
	logic [SQ_W-1:0] sqx_s3, sqy_s3, sqz_s3, sum_s4;
	logic [SQ_W-1:0] d2_q, best_q;
	logic [3*P-1:0] tset_q;

	// result staging and output
	logic res_cause_q, res_valid_q, res_done_q, res_rep_q;
	rttw_pkg::phase_t res_phase_q;
	logic [3*P-1:0] res_set_q;
	logic [7:0] res_wpn_q;
	logic out_valid_q;
	logic out_user_q;
	logic [OUT_W-1:0] out_data_q;

	logic [CNT_W-1:0] lp_base, lp_nxt;
	logic wr_en, rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [A-1:0] err_src, err;
	logic err_below, err_above;
	logic [15:0] align_nxt;
	logic last_wp, hit, active;
	logic [IDX_W+7:0] idx_wide;
	logic [7:0] wpn_now;

	assign lp_base = loading_q ? lp_q : '0;
	assign wr_en = cmd.load && (lp_base < CNT_W'(MAX_WAYPOINTS));
	assign lp_nxt = wr_en ? lp_base + CNT_W'(1) : lp_base;
	assign rd_en = cmd.rd_idx || cmd.rd_scan;
	assign rd_addr = cmd.rd_scan ? scan_q : idx_q;

	assign err_src = cmd.enter ? rd_s1[3*P +: A] : tgt_hd_q;
	assign err = herr(err_src, dhd_q);
	assign err_below = ERR_W'(err) < ERR_W'(thr_q);
	assign err_above = ERR_W'(err) > ERR_W'(thr_q);
	assign align_nxt = (align_q == 16'hFFFF) ? align_q : align_q + 16'd1;

	assign last_wp = (CNT_W'(idx_q) + CNT_W'(1)) >= pl_q;
	assign hit = d2_q < SQ_W'(last_wp ? fin_rad_q : acc_rad_q);
	assign active = (pl_q != '0) && odom_q && !fin_q;
	assign idx_wide = (IDX_W + 8)'(idx_q);
	assign wpn_now = idx_wide[7:0];

	assign cfg_ready = 1'b1;

	assign st.func = func_q;
	assign st.last = last_q;
	assign st.active = active;
	assign st.phase = ph_q;
	assign st.replan_en = ren_q;
	assign st.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign st.scan_last = (CNT_W'(scan_q) + CNT_W'(1)) == pl_q;
	assign st.advance = hit && !last_wp;
	assign st.out_blocked = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_user = out_user_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_rad_q <= rttw_pkg::ACCEPT_RAD_RST;
			fin_rad_q <= rttw_pkg::FINAL_RAD_RST;
			dev_q <= rttw_pkg::DEVIATION_RST;
			thr_q <= rttw_pkg::YAW_THR_RST;
			hold_q <= rttw_pkg::HOLD_RST;
			ren_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				rttw_pkg::REG_ACCEPT_RAD: acc_rad_q <= cfg_data;
				rttw_pkg::REG_FINAL_RAD: fin_rad_q <= cfg_data;
				rttw_pkg::REG_DEVIATION: dev_q <= cfg_data;
				rttw_pkg::REG_YAW_THR: thr_q <= cfg_data[15:0];
				rttw_pkg::REG_HOLD: hold_q <= cfg_data[15:0];
				rttw_pkg::REG_REPLAN_EN: ren_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_q <= '0;
			lp_q <= '0;
			loading_q <= 1'b0;
			idx_q <= '0;
			scan_q <= '0;
			ph_q <= rttw_pkg::PH_IDLE;
			tgt_hd_q <= '0;
			align_q <= '0;
			dhd_q <= '0;
			pose_x_q <= '0;
			pose_y_q <= '0;
			pose_z_q <= '0;
			odom_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				lp_q <= lp_nxt;
				loading_q <= !last_q;
				if (last_q) begin
					pl_q <= lp_nxt;
					idx_q <= '0;
					fin_q <= 1'b0;
				end
			end
			if (cmd.odom) begin
				pose_x_q <= ent_q[0 +: P];
				pose_y_q <= ent_q[P +: P];
				pose_z_q <= ent_q[2*P +: P];
				dhd_q <= ent_q[3*P +: A];
				odom_q <= 1'b1;
			end
			if (cmd.rot) begin
				if (err_below) begin
					align_q <= align_nxt;
					if (align_nxt >= hold_q)
						ph_q <= rttw_pkg::PH_TRANS;
				end else begin
					align_q <= '0;
				end
			end
			if (cmd.trans_start)
				scan_q <= '0;
			else if (cmd.rd_scan)
				scan_q <= scan_q + IDX_W'(1);
			if (cmd.eval && hit) begin
				if (!last_wp) begin
					idx_q <= idx_q + IDX_W'(1);
				end else begin
					ph_q <= rttw_pkg::PH_DONE;
					fin_q <= 1'b1;
				end
			end
			if (cmd.enter) begin
				tgt_hd_q <= rd_s1[3*P +: A];
				align_q <= '0;
				ph_q <= err_above ? rttw_pkg::PH_ROT : rttw_pkg::PH_TRANS;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[lp_base[IDX_W-1:0]] <= ent_q;
		if (rd_en)
			rd_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			t_s1 <= 1'b0;
			t_s2 <= 1'b0;
			t_s3 <= 1'b0;
			t_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= rd_en && cmd.rd_dist;
			t_s1 <= !cmd.rd_scan;
			v_s2 <= v_s1;
			t_s2 <= t_s1;
			v_s3 <= v_s2;
			t_s3 <= t_s2;
			v_s4 <= v_s3;
			t_s4 <= t_s3;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= rttw_pkg::func_t'(in_user);
			ent_q <= in_data[ENT_W-1:0];
			last_q <= in_last;
		end
		if (v_s1 && t_s1)
			tset_q <= rd_s1[3*P-1:0];
		mx_s2 <= mag(pose_x_q, rd_s1[0 +: P]);
		my_s2 <= mag(pose_y_q, rd_s1[P +: P]);
		mz_s2 <= mag(pose_z_q, rd_s1[2*P +: P]);
		sqx_s3 <= mx_s2 * mx_s2;
		sqy_s3 <= my_s2 * my_s2;
		sqz_s3 <= mz_s2 * mz_s2;
		sum_s4 <= t_s3 ? sqx_s3 + sqy_s3 + sqz_s3 : sqx_s3 + sqy_s3;
		if (cmd.trans_start)
			best_q <= '1;
		else if (v_s4 && !t_s4 && sum_s4 < best_q)
			best_q <= sum_s4;
		if (v_s4 && t_s4)
			d2_q <= sum_s4;

		if (cmd.load && last_q) begin
			res_cause_q <= 1'b1;
			res_set_q <= '0;
			res_valid_q <= 1'b0;
			res_wpn_q <= '0;
			res_done_q <= 1'b0;
			res_rep_q <= 1'b0;
		end
		if (cmd.res_plain) begin
			res_cause_q <= 1'b0;
			res_phase_q <= active ? ph_q : rttw_pkg::PH_IDLE;
			res_set_q <= '0;
			res_valid_q <= 1'b0;
			res_wpn_q <= wpn_now;
			res_done_q <= 1'b0;
			res_rep_q <= 1'b0;
		end
		if (cmd.rot) begin
			res_cause_q <= 1'b0;
			res_phase_q <= rttw_pkg::PH_ROT;
			res_set_q <= {pose_z_q, pose_y_q, pose_x_q};
			res_valid_q <= 1'b1;
			res_wpn_q <= wpn_now;
			res_done_q <= 1'b0;
			res_rep_q <= 1'b0;
		end
		if (cmd.trans_start) begin
			res_cause_q <= 1'b0;
			res_valid_q <= 1'b1;
			res_wpn_q <= wpn_now;
		end
		if (cmd.eval) begin
			res_phase_q <= (hit && last_wp) ? rttw_pkg::PH_DONE : rttw_pkg::PH_TRANS;
			res_set_q <= tset_q;
			res_done_q <= hit && last_wp;
			res_rep_q <= ren_q && (best_q > SQ_W'(dev_q));
		end
		if (cmd.enter && res_cause_q)
			res_phase_q <= err_above ? rttw_pkg::PH_ROT : rttw_pkg::PH_TRANS;
		if (cmd.emit) begin
			out_user_q <= res_cause_q;
			out_data_q <= OUT_W'({res_rep_q, res_done_q, res_wpn_q, res_valid_q,
				res_set_q, res_phase_q});
		end
	end
endmodule
`default_nettype wire

// ----- src/rttw_ctrl.sv -----
// controller state machine: decodes items and sequences the datapath
// depends on rttw_pkg and the assertion macro header
`default_nettype none
`include "rotate_then_translate_waypoint_sequencer_macros.svh"
module rttw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rttw_pkg::status_t st,
	output rttw_pkg::cmd_t         cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_DEC, S_SCAN, S_DRAIN, S_EVAL, S_HRD, S_HWT, S_OUT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.capture = in_valid;
			S_DEC: begin
				case (st.func)
					rttw_pkg::FN_LOAD: cmd.load = 1'b1;
					rttw_pkg::FN_ODOM: cmd.odom = 1'b1;
					rttw_pkg::FN_TICK: begin
						if (!st.active) begin
							cmd.res_plain = 1'b1;
						end else begin
							case (st.phase)
								rttw_pkg::PH_ROT: cmd.rot = 1'b1;
								rttw_pkg::PH_TRANS: begin
									cmd.trans_start = 1'b1;
									cmd.rd_idx = 1'b1;
									cmd.rd_dist = 1'b1;
								end
								default: cmd.res_plain = 1'b1;
							endcase
						end
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				cmd.rd_scan = 1'b1;
				cmd.rd_dist = 1'b1;
			end
			S_EVAL: cmd.eval = 1'b1;
			S_HRD: cmd.rd_idx = 1'b1;
			S_HWT: cmd.enter = 1'b1;
			S_OUT: cmd.emit = !st.out_blocked;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DEC;
				S_DEC: begin
					case (st.func)
						rttw_pkg::FN_LOAD: state_q <= st.last ? S_HRD : S_IDLE;
						rttw_pkg::FN_TICK: begin
							if (st.active && st.phase == rttw_pkg::PH_TRANS)
								state_q <= st.replan_en ? S_SCAN : S_DRAIN;
							else
								state_q <= S_OUT;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_SCAN: if (st.scan_last) state_q <= S_DRAIN;
				S_DRAIN: if (!st.pipe_busy) state_q <= S_EVAL;
				S_EVAL: state_q <= st.advance ? S_HRD : S_OUT;
				S_HRD: state_q <= S_HWT;
				S_HWT: state_q <= S_OUT;
				S_OUT: if (!st.out_blocked) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RTTW_ASSERT_IMP(a_emit_free, cmd.emit, !st.out_blocked, "result loaded over a held beat")
	`RTTW_ASSERT_IMP(a_eval_drained, state_q == S_EVAL, !st.pipe_busy, "evaluate before drain")
	`RTTW_ASSERT_IMP(a_scan_enabled, cmd.rd_scan, st.replan_en && st.active, "stray scan read")
	`RTTW_ASSERT_NEXT(a_accept_decode, state_q == S_IDLE && in_valid, state_q == S_DEC, "lost beat")
endmodule
`default_nettype wire
